// ----- hdl/nsv_pkg.sv -----
// nsv_pkg: shared types, character constants and codes for the nmea sentence validator
// no dependencies; imported by every module in hdl/
package nsv_pkg;

  // character constants
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // sentence length limits, expressed as the last byte position
  localparam logic [2:0] POS_MIN_LEN = 3'd3;  // four bytes
  localparam logic [2:0] POS_TAG_END = 3'd5;  // dollar plus five tag bytes

  // configuration
  localparam int unsigned TAG_W       = 40;
  localparam int unsigned CFG_DATA_W  = TAG_W;
  localparam int unsigned CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_EMPTY = 1'b0,
    CFG_TAG       = 1'b1
  } nsv_cfg_index_t;

  localparam logic [7:0]       MAX_EMPTY_RESET = 8'd1;
  localparam logic [TAG_W-1:0] TAG_RESET       = 40'h474E474741;  // "GNGGA"

  // verdict codes
  typedef enum logic [2:0] {
    REASON_OK         = 3'd0,
    REASON_SHORT      = 3'd1,
    REASON_NO_DOLLAR  = 3'd2,
    REASON_NO_TAIL    = 3'd3,
    REASON_MISMATCH   = 3'd4,
    REASON_WRONG_TAG  = 3'd5,
    REASON_MANY_EMPTY = 3'd6
  } nsv_reason_t;

  // input beat
  typedef struct packed {
    logic [7:0] sentence_byte;
    logic       end_of_sentence;
  } nsv_in_t;

  // result beat
  typedef struct packed {
    logic       accepted;
    logic [2:0] reject_reason;
    logic [7:0] computed_checksum;
  } nsv_out_t;

  // classified byte, front to back
  typedef struct packed {
    logic [2:0] pos;
    logic [7:0] char_byte;
    logic       last;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       tag_bad;
  } nsv_class_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ----- hdl/nsv_front.sv -----
// nsv_front: tracks byte position and classifies each accepted byte
// depends on nsv_pkg
module nsv_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  nsv_pkg::nsv_in_t            in_data,
  input  logic [nsv_pkg::TAG_W-1:0]   expected_tag,
  output nsv_pkg::nsv_class_t         class_data
);
  import nsv_pkg::*;

  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic [7:0] tag_byte;
  logic [4:0] hex;

  // expected tag character for this position
  always_comb begin
    case (pos_r)
      3'd1:    tag_byte = expected_tag[39:32];
      3'd2:    tag_byte = expected_tag[31:24];
      3'd3:    tag_byte = expected_tag[23:16];
      3'd4:    tag_byte = expected_tag[15:8];
      3'd5:    tag_byte = expected_tag[7:0];
      default: tag_byte = 8'd0;
    endcase
  end

  assign hex = hex_decode(in_data.sentence_byte);

  always_comb begin
    class_data.pos       = pos_r;
    class_data.char_byte = in_data.sentence_byte;
    class_data.last      = in_data.end_of_sentence;
    class_data.is_dollar = (in_data.sentence_byte == CHAR_DOLLAR);
    class_data.is_star   = (in_data.sentence_byte == CHAR_STAR);
    class_data.is_comma  = (in_data.sentence_byte == CHAR_COMMA);
    class_data.hex_ok    = hex[4];
    class_data.hex_val   = hex[3:0];
    class_data.tag_bad   = (pos_r >= 3'd1) && (pos_r <= POS_TAG_END) &&
                           (in_data.sentence_byte != tag_byte);
  end

  // position saturates at seven, restarts after the last byte
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_data.end_of_sentence) begin
        pos_nxt = 3'd0;
      end else if (pos_r != 3'd7) begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- hdl/nsv_queue.sv -----
// nsv_queue: two-entry queue of classified bytes between front and back
// depends on nsv_pkg
module nsv_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nsv_pkg::nsv_class_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output nsv_pkg::nsv_class_t  head_data
);
  import nsv_pkg::*;

  nsv_class_t mem [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/nsv_back.sv -----
// nsv_back: per-sentence check state, verdict and output register
// depends on nsv_pkg
module nsv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  nsv_pkg::nsv_class_t  head_data,
  output logic                 pop,
  input  logic [7:0]           max_empty_fields,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nsv_pkg::nsv_out_t    out_data
);
  import nsv_pkg::*;

  logic       dollar_r,  dollar_nxt;
  logic [7:0] xa_r,      xa_nxt;
  logic       star_r,    star_nxt;
  logic [1:0] cnt_r,     cnt_nxt;
  logic [7:0] rcv_r,     rcv_nxt;
  logic       bad_r,     bad_nxt;
  logic       tagok_r,   tagok_nxt;
  logic [7:0] empty_r,   empty_nxt;
  logic       prevc_r,   prevc_nxt;
  logic       out_valid_r;
  nsv_out_t   out_data_r;
  nsv_reason_t reason;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a last byte needs the output register free
  assign pop = head_valid && (!head_data.last || !out_valid_r || out_ready);

  always_comb begin
    dollar_nxt = dollar_r;
    xa_nxt     = xa_r;
    star_nxt   = star_r;
    cnt_nxt    = cnt_r;
    rcv_nxt    = rcv_r;
    bad_nxt    = bad_r;
    if (head_data.pos == 3'd0) begin
      dollar_nxt = head_data.is_dollar;
    end else if (head_data.pos == 3'd1) begin
      xa_nxt = head_data.char_byte;
    end else if (!star_r) begin
      if (head_data.is_star) begin
        star_nxt = 1'b1;
      end else begin
        xa_nxt = xa_r ^ head_data.char_byte;
      end
    end else begin
      if (cnt_r != 2'd3) begin
        cnt_nxt = cnt_r + 2'd1;
      end
      if (head_data.hex_ok) begin
        rcv_nxt = {rcv_r[3:0], head_data.hex_val};
      end else begin
        bad_nxt = 1'b1;
      end
    end
    tagok_nxt = tagok_r && !head_data.tag_bad;
    empty_nxt = empty_r;
    if (head_data.is_comma && prevc_r && empty_r != 8'hFF) begin
      empty_nxt = empty_r + 8'd1;
    end
    prevc_nxt = head_data.is_comma;
  end

  always_comb begin
    if (head_data.pos < POS_MIN_LEN) begin
      reason = REASON_SHORT;
    end else if (!dollar_nxt) begin
      reason = REASON_NO_DOLLAR;
    end else if (!star_nxt || cnt_nxt == 2'd0) begin
      reason = REASON_NO_TAIL;
    end else if (cnt_nxt != 2'd2 || bad_nxt || rcv_nxt != xa_nxt) begin
      reason = REASON_MISMATCH;
    end else if (!tagok_nxt || head_data.pos < POS_TAG_END) begin
      reason = REASON_WRONG_TAG;
    end else if (empty_nxt > max_empty_fields) begin
      reason = REASON_MANY_EMPTY;
    end else begin
      reason = REASON_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dollar_r <= 1'b0;
      xa_r     <= 8'd0;
      star_r   <= 1'b0;
      cnt_r    <= 2'd0;
      rcv_r    <= 8'd0;
      bad_r    <= 1'b0;
      tagok_r  <= 1'b1;
      empty_r  <= 8'd0;
      prevc_r  <= 1'b0;
    end else if (pop) begin
      if (head_data.last) begin
        dollar_r <= 1'b0;
        xa_r     <= 8'd0;
        star_r   <= 1'b0;
        cnt_r    <= 2'd0;
        rcv_r    <= 8'd0;
        bad_r    <= 1'b0;
        tagok_r  <= 1'b1;
        empty_r  <= 8'd0;
        prevc_r  <= 1'b0;
      end else begin
        dollar_r <= dollar_nxt;
        xa_r     <= xa_nxt;
        star_r   <= star_nxt;
        cnt_r    <= cnt_nxt;
        rcv_r    <= rcv_nxt;
        bad_r    <= bad_nxt;
        tagok_r  <= tagok_nxt;
        empty_r  <= empty_nxt;
        prevc_r  <= prevc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_data.last) begin
      out_data_r.accepted          <= (reason == REASON_OK);
      out_data_r.reject_reason     <= reason;
      out_data_r.computed_checksum <= xa_nxt;
    end
  end

endmodule

// ----- hdl/nmea_sentence_validator_core.sv -----
// nmea_sentence_validator_core: top level of the nmea 0183 sentence validator
// depends on nsv_pkg, nsv_front, nsv_queue, nsv_back
//
// Takes one sentence character per beat on in_ (end_of_sentence marks the last one) and
// returns one verdict beat on out_ for each sentence: accepted, reject_reason and the XOR
// checksum of the body. Checks run in order: length of at least four, leading '$', a '*'
// at position two or later with a non-empty tail, a two-digit hex checksum (either case)
// equal to the body XOR, the five tag characters against expected_tag, and the number of
// empty fields (comma right after comma) against max_empty_fields. Throughput is one byte
// per clock while out_ready takes verdicts, and the verdict is registered once its last byte
// has left the queue. The front stage classifies each byte and tracks its position; a
// two-beat queue lets it keep taking bytes while the back stage waits for a held verdict
// to be taken. Configuration writes (cfg_index 0: max_empty_fields, 1: expected_tag) take
// effect at once and belong between sentences, with no beat in flight.
module nmea_sentence_validator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input bytes
  input  logic                                in_valid,
  output logic                                in_ready,
  input  nsv_pkg::nsv_in_t                    in_data,
  // verdicts
  output logic                                out_valid,
  input  logic                                out_ready,
  output nsv_pkg::nsv_out_t                   out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [nsv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [nsv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import nsv_pkg::*;

  logic [7:0]       max_empty_r;
  logic [TAG_W-1:0] tag_r;

  logic       in_accept;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  nsv_class_t front_class;
  nsv_class_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_empty_r <= MAX_EMPTY_RESET;
      tag_r       <= TAG_RESET;
    end else if (cfg_we) begin
      unique case (nsv_cfg_index_t'(cfg_index))
        CFG_MAX_EMPTY: max_empty_r <= cfg_wdata[7:0];
        CFG_TAG:       tag_r       <= cfg_wdata[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // front takes a beat whenever the queue has room
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  nsv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .in_data      (in_data),
    .expected_tag (tag_r),
    .class_data   (front_class)
  );

  nsv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (front_class),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  nsv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_valid),
    .head_data        (q_head),
    .pop              (q_pop),
    .max_empty_fields (max_empty_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

`ifndef NO_ASSERTIONS
  // a full queue is never empty at its head
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_valid)
    else $error("queue full with no head entry");

  // back never pops from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a popped last byte shows up as a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last) |=> out_valid)
    else $error("last byte popped without verdict");

  // accepted flag agrees with the reason code
  a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.accepted == (out_data.reject_reason == REASON_OK)))
    else $error("accepted flag disagrees with reject reason");
`endif

endmodule
